[src/scar_pkg.sv]
// Shared constants, types and arithmetic helpers of the stereo comb/allpass reverb.
// Used by the interfaces, the rounding multiplier and the top level; depends on nothing.
package scar_pkg;

	localparam int COMB_MAX_LEN_DEF    = 2048;
	localparam int ALLPASS_MAX_LEN_DEF = 1024;

	localparam int SAMPLE_W   = 24;
	localparam int WORD_W     = 32;
	localparam int COEF_W     = 16;
	localparam int DIFF_W     = WORD_W + 1;
	localparam int PROD_W     = WORD_W + 2;
	localparam int ACC_W      = WORD_W + 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam int NUM_COMBS    = 4;
	localparam int NUM_ALLPASS  = 2;
	localparam int COMB_LINES   = 2 * NUM_COMBS;
	localparam int AP_LINES     = 2 * NUM_ALLPASS;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_COMB_GAINS    = 3'd0,
		REG_ALLPASS_GAINS = 3'd1,
		REG_DAMPING       = 3'd2,
		REG_INPUT_GAIN    = 3'd3,
		REG_LOWCUT        = 3'd4
	} reg_idx_t;

	typedef logic signed [WORD_W-1:0]   word_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// comb lengths: left lines 0..3, right lines 4..7
	function automatic int comb_len(input int max_len, input int line);
		int k;
		case (line)
			0:       k = 53;
			1:       k = 57;
			2:       k = 60;
			3:       k = 64;
			4:       k = 52;
			5:       k = 56;
			6:       k = 59;
			default: k = 63;
		endcase
		return (max_len * k) / 64;
	endfunction

	// allpass lengths: left lines 0..1, right lines 2..3
	function automatic int ap_len(input int max_len, input int line);
		int k;
		case (line)
			0:       k = 64;
			1:       k = 51;
			2:       k = 62;
			default: k = 49;
		endcase
		return (max_len * k) / 64;
	endfunction

	function automatic word_t sat32(input acc_t v);
		word_t r;
		if (v[ACC_W-1:WORD_W-1] == '0 || v[ACC_W-1:WORD_W-1] == '1) begin
			r = v[WORD_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic sample_t sat24(input acc_t v);
		sample_t r;
		if (v[ACC_W-1:SAMPLE_W-1] == '0 || v[ACC_W-1:SAMPLE_W-1] == '1) begin
			r = v[SAMPLE_W-1:0];
		end else if (v[ACC_W-1]) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

[src/scar_ifs.sv]
// Channel interfaces of the reverb: sample requests in, results out, register writes.
// Depends on scar_pkg.
interface scar_in_if;
	logic                     valid;
	logic                     ready;
	logic signed [scar_pkg::SAMPLE_W-1:0] in_left;
	logic signed [scar_pkg::SAMPLE_W-1:0] in_right;
	modport source(output valid, output in_left, output in_right, input ready);
	modport sink(input valid, input in_left, input in_right, output ready);
endinterface

interface scar_out_if;
	logic                     valid;
	logic                     ready;
	logic signed [scar_pkg::SAMPLE_W-1:0] out_left;
	logic signed [scar_pkg::SAMPLE_W-1:0] out_right;
	modport source(output valid, output out_left, output out_right, input ready);
	modport sink(input valid, input out_left, input out_right, output ready);
endinterface

interface scar_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [scar_pkg::CFG_IDX_W-1:0]     index;
	logic [scar_pkg::CFG_DATA_W-1:0]    data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[src/stereo_comb_allpass_reverb.sv]
// Top level of the stereo reverb: register file, sequencer, delay memories.
// Depends on scar_pkg, scar_ifs and scar_mulq.
//
// Each accepted stereo request runs the left channel, then the right, through one shared
// rounding multiplier; a channel takes gain, four combs of five steps, two allpasses,
// low cut and output. The next request is taken once the result is registered for output,
// which waits while an earlier result is still held unread. The multiplier and the delay
// memory reads are registered. Delay memories need no clearing after reset: a line reads
// as zero until its position has wrapped once. Register writes are always taken.
module stereo_comb_allpass_reverb #(
	parameter int COMB_MAX_LEN    = scar_pkg::COMB_MAX_LEN_DEF,
	parameter int ALLPASS_MAX_LEN = scar_pkg::ALLPASS_MAX_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	scar_in_if.sink       samples,
	scar_out_if.source    results,
	scar_cfg_if.sink      cfg
);
	localparam int CPW = $clog2(COMB_MAX_LEN);
	localparam int APW = $clog2(ALLPASS_MAX_LEN);
	localparam int CW  = scar_pkg::COEF_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_GAIN, ST_XSET, ST_CM1, ST_CA1, ST_CM2, ST_CA2, ST_ACC,
		ST_AM1, ST_AA1, ST_AM2, ST_AA2, ST_ARD, ST_LM, ST_LA, ST_OUT
	} state_t;

	state_t state_q;

	logic [4*CW-1:0] comb_gains_q;
	logic [2*CW-1:0] ap_gains_q;
	logic [CW-1:0]   damping_q;
	logic [CW-1:0]   input_gain_q;
	logic [CW-1:0]   lowcut_q;

	logic        ch_q;
	logic [1:0]  j_q;
	logic        ap_phase_q;

	logic [CPW-1:0] comb_pos_q  [scar_pkg::COMB_LINES];
	logic [APW-1:0] ap_pos_q    [scar_pkg::AP_LINES];
	logic           comb_full_q [scar_pkg::COMB_LINES];
	logic           ap_full_q   [scar_pkg::AP_LINES];
	scar_pkg::word_t damper_q   [scar_pkg::COMB_LINES];
	scar_pkg::word_t lowcut_st_q [2];

	scar_pkg::sample_t dry_l_q, dry_r_q, res_l_q;
	scar_pkg::word_t   x_q, cur_q, nv_q, lp_q, dv_q, dz_q;

	scar_pkg::sample_t out_l_q, out_r_q;
	logic              out_valid_q;

	scar_pkg::word_t comb_mem [scar_pkg::COMB_LINES][COMB_MAX_LEN];
	scar_pkg::word_t ap_mem   [scar_pkg::AP_LINES][ALLPASS_MAX_LEN];
	scar_pkg::word_t comb_rd_q, ap_rd_q;

	logic [2:0]     cline;
	logic [1:0]     aline;
	logic [CPW-1:0] cpos;
	logic [APW-1:0] apos;
	logic [CPW:0]   cpos_nx, clen;
	logic [APW:0]   apos_nx, alen;
	logic           comb_we, ap_we;
	scar_pkg::word_t comb_dv, ap_dv, dry_w, ls_cur, lp_new, dz_new;
	scar_pkg::sample_t dry;
	logic signed [scar_pkg::DIFF_W-1:0] mul_a;
	logic [CW-1:0]  mul_g, comb_g, ap_g;
	logic signed [scar_pkg::PROD_W-1:0] prod_q;
	scar_pkg::acc_t nv_sum;

	assign cline   = {ch_q, j_q};
	assign aline   = {ch_q, j_q[0]};
	assign cpos    = comb_pos_q[cline];
	assign apos    = ap_pos_q[aline];
	assign cpos_nx = {1'b0, cpos} + 1'b1;
	assign apos_nx = {1'b0, apos} + 1'b1;
	assign clen    = (CPW+1)'(scar_pkg::comb_len(COMB_MAX_LEN, int'(cline)));
	assign alen    = (APW+1)'(scar_pkg::ap_len(ALLPASS_MAX_LEN, int'(aline)));
	assign comb_dv = comb_full_q[cline] ? comb_rd_q : '0;
	assign ap_dv   = ap_full_q[aline] ? ap_rd_q : '0;
	assign dry     = ch_q ? dry_r_q : dry_l_q;
	assign dry_w   = scar_pkg::WORD_W'(dry);
	assign ls_cur  = lowcut_st_q[ch_q];
	assign comb_g  = comb_gains_q[j_q*CW +: CW];
	assign ap_g    = ap_gains_q[j_q[0]*CW +: CW];
	assign comb_we = (state_q == ST_CA2);
	assign ap_we   = (state_q == ST_AA1);

	assign lp_new = scar_pkg::sat32(scar_pkg::ACC_W'(lp_q) + scar_pkg::ACC_W'(prod_q));
	assign dz_new = scar_pkg::sat32(scar_pkg::ACC_W'(cur_q) + scar_pkg::ACC_W'(prod_q));
	assign nv_sum = j_q[0] ? scar_pkg::ACC_W'(prod_q) - scar_pkg::ACC_W'(x_q)
		: scar_pkg::ACC_W'(prod_q) + scar_pkg::ACC_W'(x_q);

	always_comb begin
		mul_a = '0;
		mul_g = '0;
		case (state_q)
			ST_GAIN: begin
				mul_a = scar_pkg::DIFF_W'(dry);
				mul_g = input_gain_q;
			end
			ST_CM1: begin
				mul_a = scar_pkg::DIFF_W'(comb_dv);
				mul_g = comb_g;
			end
			ST_CM2: begin
				mul_a = scar_pkg::DIFF_W'(nv_q) - scar_pkg::DIFF_W'(lp_q);
				mul_g = damping_q;
			end
			ST_AM1: begin
				mul_a = scar_pkg::DIFF_W'(ap_dv);
				mul_g = ap_g;
			end
			ST_AM2: begin
				mul_a = scar_pkg::DIFF_W'(dz_q);
				mul_g = ap_g;
			end
			ST_LM: begin
				mul_a = scar_pkg::DIFF_W'(cur_q) - scar_pkg::DIFF_W'(ls_cur);
				mul_g = lowcut_q;
			end
			default: begin
				mul_a = '0;
				mul_g = '0;
			end
		endcase
	end

	scar_mulq u_mulq (
		.clk (clk),
		.a   (mul_a),
		.g   (mul_g),
		.p_q (prod_q)
	);

	always_ff @(posedge clk) begin
		if (comb_we) begin
			comb_mem[cline][cpos] <= lp_new;
		end
		comb_rd_q <= comb_mem[cline][cpos];
	end

	always_ff @(posedge clk) begin
		if (ap_we) begin
			ap_mem[aline][apos] <= dz_new;
		end
		ap_rd_q <= ap_mem[aline][apos];
	end

	assign cfg.ready       = 1'b1;
	assign samples.ready   = (state_q == ST_IDLE);
	assign results.valid   = out_valid_q;
	assign results.out_left  = out_l_q;
	assign results.out_right = out_r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comb_gains_q <= '0;
			ap_gains_q   <= '0;
			damping_q    <= '0;
			input_gain_q <= '0;
			lowcut_q     <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				scar_pkg::REG_COMB_GAINS:    comb_gains_q <= cfg.data;
				scar_pkg::REG_ALLPASS_GAINS: ap_gains_q   <= cfg.data[2*CW-1:0];
				scar_pkg::REG_DAMPING:       damping_q    <= cfg.data[CW-1:0];
				scar_pkg::REG_INPUT_GAIN:    input_gain_q <= cfg.data[CW-1:0];
				scar_pkg::REG_LOWCUT:        lowcut_q     <= cfg.data[CW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			j_q         <= '0;
			ap_phase_q  <= 1'b0;
			out_valid_q <= 1'b0;
			out_l_q     <= '0;
			out_r_q     <= '0;
			dry_l_q     <= '0;
			dry_r_q     <= '0;
			res_l_q     <= '0;
			x_q         <= '0;
			cur_q       <= '0;
			nv_q        <= '0;
			lp_q        <= '0;
			dv_q        <= '0;
			dz_q        <= '0;
			for (int i = 0; i < scar_pkg::COMB_LINES; i++) begin
				comb_pos_q[i]  <= '0;
				comb_full_q[i] <= 1'b0;
				damper_q[i]    <= '0;
			end
			for (int i = 0; i < scar_pkg::AP_LINES; i++) begin
				ap_pos_q[i]  <= '0;
				ap_full_q[i] <= 1'b0;
			end
			lowcut_st_q[0] <= '0;
			lowcut_st_q[1] <= '0;
		end else begin
			if (out_valid_q && results.ready && !(state_q == ST_OUT && ch_q)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						dry_l_q    <= samples.in_left;
						dry_r_q    <= samples.in_right;
						ch_q       <= 1'b0;
						j_q        <= '0;
						ap_phase_q <= 1'b0;
						state_q    <= ST_GAIN;
					end
				end
				ST_GAIN: state_q <= ST_XSET;
				ST_XSET: begin
					x_q     <= prod_q[scar_pkg::WORD_W-1:0];
					cur_q   <= '0;
					state_q <= ST_CM1;
				end
				ST_CM1: state_q <= ST_CA1;
				ST_CA1: begin
					nv_q    <= scar_pkg::sat32(nv_sum);
					lp_q    <= damper_q[cline];
					state_q <= ST_CM2;
				end
				ST_CM2: state_q <= ST_CA2;
				ST_CA2: begin
					damper_q[cline] <= lp_new;
					lp_q            <= lp_new;
					if (cpos_nx == clen) begin
						comb_pos_q[cline]  <= '0;
						comb_full_q[cline] <= 1'b1;
					end else begin
						comb_pos_q[cline] <= cpos_nx[CPW-1:0];
					end
					if (j_q == 2'd3) begin
						ap_phase_q <= 1'b1;
						j_q        <= '0;
					end else begin
						j_q <= j_q + 2'd1;
					end
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					cur_q <= scar_pkg::sat32(scar_pkg::ACC_W'(cur_q) + scar_pkg::ACC_W'(lp_q));
					state_q <= ap_phase_q ? ST_AM1 : ST_CM1;
				end
				ST_AM1: begin
					dv_q    <= ap_dv;
					state_q <= ST_AA1;
				end
				ST_AA1: begin
					dz_q <= dz_new;
					if (apos_nx == alen) begin
						ap_pos_q[aline]  <= '0;
						ap_full_q[aline] <= 1'b1;
					end else begin
						ap_pos_q[aline] <= apos_nx[APW-1:0];
					end
					state_q <= ST_AM2;
				end
				ST_AM2: state_q <= ST_AA2;
				ST_AA2: begin
					cur_q <= scar_pkg::sat32(scar_pkg::ACC_W'(dv_q) - scar_pkg::ACC_W'(prod_q));
					if (j_q[0]) begin
						state_q <= ST_LM;
					end else begin
						j_q     <= 2'd1;
						state_q <= ST_ARD;
					end
				end
				ST_ARD: state_q <= ST_AM1;
				ST_LM:  state_q <= ST_LA;
				ST_LA: begin
					lowcut_st_q[ch_q] <= scar_pkg::sat32(scar_pkg::ACC_W'(ls_cur)
						+ scar_pkg::ACC_W'(prod_q));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!ch_q) begin
						res_l_q <= scar_pkg::sat24(scar_pkg::ACC_W'(dry_w)
							+ scar_pkg::ACC_W'(cur_q) - scar_pkg::ACC_W'(ls_cur));
						ch_q       <= 1'b1;
						j_q        <= '0;
						ap_phase_q <= 1'b0;
						state_q    <= ST_GAIN;
					end else if (!out_valid_q || results.ready) begin
						out_l_q     <= res_l_q;
						out_r_q     <= scar_pkg::sat24(scar_pkg::ACC_W'(dry_w)
							+ scar_pkg::ACC_W'(cur_q) - scar_pkg::ACC_W'(ls_cur));
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_comb_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cpos} < clen)
		else $error("comb position beyond line length");

	a_ap_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, apos} < alen)
		else $error("allpass position beyond line length");

	a_blocked_result_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && ch_q && out_valid_q && !results.ready) |=> state_q == ST_OUT)
		else $error("result overwritten while output held");

	a_comb_write_phase: assert property (@(posedge clk) disable iff (!arst_n)
		comb_we |-> !ap_phase_q)
		else $error("comb write during allpass phase");
endmodule

[src/scar_mulq.sv]
// Registered Q0.16 multiply with round half up and floor shift.
// Depends on scar_pkg.
module scar_mulq (
	input  logic                                  clk,
	input  logic signed [scar_pkg::DIFF_W-1:0]    a,
	input  logic        [scar_pkg::COEF_W-1:0]    g,
	output logic signed [scar_pkg::PROD_W-1:0]    p_q
);
	localparam int FULL_W = scar_pkg::DIFF_W + scar_pkg::COEF_W + 1;

	logic signed [FULL_W-1:0] full;

	assign full = FULL_W'(a) * FULL_W'($signed({1'b0, g}))
		+ FULL_W'(32'sd32768);

	always_ff @(posedge clk) begin
		p_q <= full[scar_pkg::PROD_W+scar_pkg::COEF_W-1:scar_pkg::COEF_W];
	end
endmodule
